// ===== hdl/q16div_pkg.sv =====
// Shared types and constants for the signed Q16.16 fixed-point divider.
// This package depends on nothing else. Every other file uses it.
`default_nettype none

package q16div_pkg;

  // Width of the operand and result words.
  localparam int unsigned DATA_W = 32;

  // Default fraction width and the number of quotient bits resolved per pipeline stage.
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned STEPS_DEF     = 4;

  // Limits on the quotient magnitude that still fit in a signed 32-bit result.
  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] dividend;
    logic signed [DATA_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient;
    logic                     div_by_zero;
    logic                     overflow;
  } out_t;

  // Flags that travel down the divide pipeline next to the remainder.
  typedef struct packed {
    logic neg;  // The operand signs differ.
    logic dz;   // The divisor is zero.
  } div_flags_t;

endpackage : q16div_pkg

`default_nettype wire

// ===== hdl/signed_q16_fixed_point_divider_top.sv =====
// Top level of the signed Q16.16 fixed-point divider pipeline.
// This module depends on q16div_pkg and instantiates q16div_stage.
//
// Usage:
// The input channel (in_valid_i, in_stall_o, in_data_i) carries a signed
// dividend and divisor. A transfer happens at a rising clock edge where valid
// is high and stall is low. The output channel (out_valid_o, out_stall_i,
// out_data_o) returns the low 32 bits of (dividend << FRAC_BITS) / divisor,
// truncated toward zero, with a divide-by-zero flag and an overflow flag.
// A zero divisor gives a zero quotient with the overflow flag clear.
// Throughput is one transfer per cycle while the receiver does not stall.
// Let NDIV = ceil((32 + FRAC_BITS) / STEPS_PER_STAGE). One register takes the
// operand magnitudes, NDIV restoring divide stages each resolve STEPS_PER_STAGE
// quotient bits, and the output register applies the sign and the flags.
// Each stage has its own valid bit. A stage loads when it is empty or when
// the stage after it moves on. When the receiver stalls, the pipeline packs
// its bubbles first. Input stalls only once every stage holds an item.
// Reset clears all valid bits. The block keeps no other state.
`default_nettype none

module signed_q16_fixed_point_divider_top #(
  parameter int unsigned FRAC_BITS       = q16div_pkg::FRAC_BITS_DEF,
  parameter int unsigned STEPS_PER_STAGE = q16div_pkg::STEPS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire q16div_pkg::in_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output q16div_pkg::out_t      out_data_o
);

  localparam int unsigned W    = q16div_pkg::DATA_W;
  localparam int unsigned DW   = W + FRAC_BITS;
  localparam int unsigned NDIV = (DW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Index 0 is the operand stage. Index k+1 is the output of divide stage k.
  logic                   vld_w [NDIV+1];
  q16div_pkg::div_flags_t flg_w [NDIV+1];
  logic [W-1:0]           dvs_w [NDIV+1];
  logic [W-1:0]           rem_w [NDIV+1];
  logic [DW-1:0]          aq_w  [NDIV+1];

  // Load enables. Index NDIV+1 belongs to the output register.
  logic [NDIV+1:0]        en_w;

  // Operand stage: take magnitudes and record the sign and zero-divisor flags.
  logic                   s0_valid_q;
  q16div_pkg::div_flags_t s0_flags_q, s0_flags_d;
  logic [W-1:0]           s0_dvs_q, s0_dvs_d;
  logic [DW-1:0]          s0_aq_q, s0_aq_d;

  logic                   out_valid_q;
  q16div_pkg::out_t       out_q, out_d;

  assign en_w[NDIV+1] = !out_valid_q || !out_stall_i;

  for (genvar i = 0; i <= NDIV; i++) begin : g_en
    assign en_w[i] = !vld_w[i] || en_w[i+1];
  end

  assign in_stall_o = !en_w[0];

  always_comb begin
    logic [W-1:0] a, b, ma;
    a  = in_data_i.dividend;
    b  = in_data_i.divisor;
    ma = a[W-1] ? W'(0 - a) : a;
    s0_dvs_d       = b[W-1] ? W'(0 - b) : b;
    s0_flags_d.neg = a[W-1] ^ b[W-1];
    s0_flags_d.dz  = (b == '0);
    s0_aq_d        = DW'(ma) << FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en_w[0]) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w[0]) begin
      s0_flags_q <= s0_flags_d;
      s0_dvs_q   <= s0_dvs_d;
      s0_aq_q    <= s0_aq_d;
    end
  end

  assign vld_w[0] = s0_valid_q;
  assign flg_w[0] = s0_flags_q;
  assign dvs_w[0] = s0_dvs_q;
  assign rem_w[0] = '0;
  assign aq_w[0]  = s0_aq_q;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    q16div_stage #(
      .DW        (DW),
      .STEPS     (STEPS_PER_STAGE),
      .FIRST_STEP(k * STEPS_PER_STAGE)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en_w[k+1]),
      .valid_i  (vld_w[k]),
      .flags_i  (flg_w[k]),
      .divisor_i(dvs_w[k]),
      .rem_i    (rem_w[k]),
      .aq_i     (aq_w[k]),
      .valid_o  (vld_w[k+1]),
      .flags_o  (flg_w[k+1]),
      .divisor_o(dvs_w[k+1]),
      .rem_o    (rem_w[k+1]),
      .aq_o     (aq_w[k+1])
    );
  end

  // Output stage. After all steps aq holds the unsigned quotient magnitude.
  // The overflow check compares that magnitude with the signed range.
  always_comb begin
    logic [63:0] q64;
    logic [W-1:0] qlo;
    q64 = 64'(aq_w[NDIV]);
    qlo = aq_w[NDIV][W-1:0];
    if (flg_w[NDIV].dz) begin
      out_d.quotient    = '0;
      out_d.div_by_zero = 1'b1;
      out_d.overflow    = 1'b0;
    end else if (flg_w[NDIV].neg) begin
      out_d.quotient    = W'(0 - qlo);
      out_d.div_by_zero = 1'b0;
      out_d.overflow    = (q64 > q16div_pkg::NEG_LIMIT);
    end else begin
      out_d.quotient    = qlo;
      out_d.div_by_zero = 1'b0;
      out_d.overflow    = (q64 > q16div_pkg::POS_LIMIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_w[NDIV+1]) begin
      out_valid_q <= vld_w[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w[NDIV+1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : signed_q16_fixed_point_divider_top

`default_nettype wire

// ===== hdl/q16div_stage.sv =====
// One register stage of the restoring divider that resolves STEPS quotient bits.
// This module depends on q16div_pkg for the word width and the flag struct.
`default_nettype none

module q16div_stage #(
  parameter int unsigned DW         = 48,
  parameter int unsigned STEPS      = 4,
  parameter int unsigned FIRST_STEP = 0
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire q16div_pkg::div_flags_t          flags_i,
  input  wire logic [q16div_pkg::DATA_W-1:0]   divisor_i,
  input  wire logic [q16div_pkg::DATA_W-1:0]   rem_i,
  input  wire logic [DW-1:0]                   aq_i,
  output logic                                 valid_o,
  output q16div_pkg::div_flags_t               flags_o,
  output logic [q16div_pkg::DATA_W-1:0]        divisor_o,
  output logic [q16div_pkg::DATA_W-1:0]        rem_o,
  output logic [DW-1:0]                        aq_o
);

  localparam int unsigned W = q16div_pkg::DATA_W;

  logic                   valid_q;
  q16div_pkg::div_flags_t flags_q;
  logic [W-1:0]           divisor_q;
  logic [W-1:0]           rem_q, rem_d;
  logic [DW-1:0]          aq_q, aq_d;

  // The remainder stays below the divisor, so it fits the word width. The
  // dividend bits shift out of the top of aq while quotient bits shift in below.
  always_comb begin
    logic [W:0] trial;
    logic       ge;
    rem_d = rem_i;
    aq_d  = aq_i;
    for (int j = 0; j < int'(STEPS); j++) begin
      if (int'(FIRST_STEP) + j < int'(DW)) begin
        trial = {rem_d, aq_d[DW-1]};
        ge    = (trial >= {1'b0, divisor_i});
        rem_d = ge ? W'(trial - {1'b0, divisor_i}) : trial[W-1:0];
        aq_d  = {aq_d[DW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q   <= flags_i;
      divisor_q <= divisor_i;
      rem_q     <= rem_d;
      aq_q      <= aq_d;
    end
  end

  assign valid_o   = valid_q;
  assign flags_o   = flags_q;
  assign divisor_o = divisor_q;
  assign rem_o     = rem_q;
  assign aq_o      = aq_q;

endmodule : q16div_stage

`default_nettype wire

// ===== hdl/q16div_checker.sv =====
// Port-level assertions for the divider top level, with the bind that attaches them.
// This file depends on q16div_pkg and on signed_q16_fixed_point_divider_top.
`default_nettype none

module q16div_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire q16div_pkg::in_t  in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire q16div_pkg::out_t out_data_o
);

  // A stalled operand transfer stays offered and its payload does not change.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled operands changed or dropped");

  // A stalled result stays valid and does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A result goes away only after a transfer took it.
  a_out_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without a transfer");

  // The input backs up only when a result is waiting on a stalled receiver.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline can move");

  // A zero divisor yields a zero quotient and no overflow.
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.div_by_zero |->
      out_data_o.quotient == '0 && !out_data_o.overflow)
    else $error("divide-by-zero result is not clean");

endmodule : q16div_checker

bind signed_q16_fixed_point_divider_top q16div_checker u_q16div_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== tb/signed_q16_fixed_point_divider_top_tb.sv =====
// Self-checking testbench for the signed Q16.16 fixed-point divider pipeline.
// Depends on q16div_pkg for the transfer types and on signed_q16_fixed_point_divider_top.
`default_nettype none

module signed_q16_fixed_point_divider_top_tb;
  import q16div_pkg::*;

  localparam int unsigned FRAC_W       = FRAC_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1650;
  // The length of the one long refusal of results in the run, which is far
  // longer than the pipeline is deep, so the input side has to stall.
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned DRAIN_CYCLES = 24;
  // Simulation time limit that ends a run that hangs.
  localparam int unsigned RUN_LIMIT    = 2_000_000;
  localparam int unsigned MAX_REPORTS  = 60;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // Holds the quotients still owed by the pipeline, in transfer order.
  class quotient_scoreboard;
    out_t        pending_quotients[$];
    int unsigned results_seen;
    int unsigned mismatches;

    // Magnitude divide in 64 bits, then the sign and the range flags are applied.
    function out_t predict_quotient(in_t op);
      logic [31:0] mag_n, mag_d;
      logic [63:0] num, q, q_neg;
      logic        negate;
      out_t        r;
      r     = '0;
      mag_n = op.dividend;
      mag_d = op.divisor;
      if (mag_n[31]) mag_n = ~mag_n + 32'd1;
      if (mag_d[31]) mag_d = ~mag_d + 32'd1;
      if (mag_d == 32'd0) begin
        r.div_by_zero = 1'b1;
        return r;
      end
      num    = {32'd0, mag_n} << FRAC_W;
      q      = num / {32'd0, mag_d};
      negate = op.dividend[31] ^ op.divisor[31];
      if (negate) begin
        q_neg      = ~q + 64'd1;
        r.quotient = q_neg[31:0];
        r.overflow = (q > NEG_LIMIT);
      end else begin
        r.quotient = q[31:0];
        r.overflow = (q > POS_LIMIT);
      end
      return r;
    endfunction

    function void note_operands(in_t op);
      pending_quotients.push_back(predict_quotient(op));
    endfunction

    function void flag_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %h, actual %h", field, exp_v, got_v);
    endfunction

    function void check_quotient(out_t got);
      out_t exp_r;
      results_seen++;
      if (pending_quotients.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("result %h with no transfer waiting for it", got);
        return;
      end
      exp_r = pending_quotients.pop_front();
      if (got.quotient !== exp_r.quotient)
        flag_mismatch("quotient", exp_r.quotient, got.quotient);
      if (got.div_by_zero !== exp_r.div_by_zero)
        flag_mismatch("div_by_zero", 32'(exp_r.div_by_zero), 32'(got.div_by_zero));
      if (got.overflow !== exp_r.overflow)
        flag_mismatch("overflow", 32'(exp_r.overflow), 32'(got.overflow));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  quotient_scoreboard sb = new;

  signed_q16_fixed_point_divider_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Every result transfer is checked at the rising edge where it happens.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_quotient(out_data);
  end

  function automatic in_t make_op(logic [31:0] a, logic [31:0] b);
    in_t op;
    op.dividend = a;
    op.divisor  = b;
    return op;
  endfunction

  function automatic logic [31:0] corner_value(int unsigned idx);
    case (idx)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h0001_0000;
      6:       return 32'hFFFF_0000;
      default: return 32'h0000_8000;
    endcase
  endfunction

  // Random operands, weighted toward the regions where the flags and the wrap matter.
  function automatic in_t random_operands();
    logic [31:0] a, b, mag;
    logic [63:0] wide;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    a    = $urandom;
    b    = $urandom;
    if (pick == 0) begin
      // Zero divisor with any dividend.
      b = 32'd0;
    end else if (pick <= 6) begin
      // Full-range operands on both fields.
    end else if (pick <= 9) begin
      // Small divisors make large quotients, so overflow and wrap show up often.
      mag = $urandom_range(1, 65535);
      b   = $urandom_range(0, 1) ? -mag : mag;
    end else if (pick <= 12) begin
      // Dividend within two of divisor * 2^15, so the quotient magnitude lands near 2^31 on either sign.
      mag  = $urandom_range(1, 65535);
      wide = {32'd0, mag} * 64'd32768;
      a    = wide[31:0] + $urandom_range(0, 4) - 32'd2;
      b    = mag;
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
    end else if (pick <= 14) begin
      a = corner_value($urandom_range(0, 7));
      b = corner_value($urandom_range(0, 7));
    end else begin
      // Typical fixed-point values of moderate size.
      a = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      b = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      if (b == 32'd0) b = 32'd1;
    end
    return make_op(a, b);
  endfunction

  // Called just after a falling edge. Valid and the payload hold until the transfer,
  // and the task returns at the falling edge after the transfer so the caller can drive again.
  task automatic send_operands(input in_t op);
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_operands(op);
    @(negedge clk);
  endtask

  task automatic pause_input(input int unsigned cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Receiver back-pressure: segments of random length, each with its own stall pattern,
  // and one long refusal once 400 results have come back.
  initial begin : result_stall_gen
    stall_mode_e mode;
    int unsigned seg_left;
    int unsigned period;
    int unsigned phase;
    bit          long_hold_done;
    out_stall      = 1'b0;
    mode           = STALL_NONE;
    seg_left       = 0;
    period         = 2;
    phase          = 0;
    long_hold_done = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!long_hold_done && sb.results_seen >= 400) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
          period   = $urandom_range(2, 6);
          phase    = 0;
        end
        seg_left--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((phase % period) == 0);
        endcase
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : operand_stream
    int unsigned sent;
    int unsigned burst_left;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: unit values, truncation toward zero, the full-scale extremes,
    // the exact edges of the signed range on both signs, and zero divisors.
    send_operands(make_op(32'h0001_0000, 32'h0001_0000));
    send_operands(make_op(32'h0003_0000, 32'h0002_0000));
    send_operands(make_op(32'hFFFF_FFFF, 32'h0000_0003));
    send_operands(make_op(32'h0000_0001, 32'h0003_0000));
    send_operands(make_op(32'h0000_0001, 32'h0000_0002));
    send_operands(make_op(32'hFFFF_0000, 32'h0001_0000));
    send_operands(make_op(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_operands(make_op(32'h8000_0000, 32'h8000_0000));
    send_operands(make_op(32'h8000_0000, 32'h7FFF_FFFF));
    send_operands(make_op(32'h7FFF_FFFF, 32'h8000_0000));
    send_operands(make_op(32'h8000_0000, 32'hFFFF_FFFF));
    send_operands(make_op(32'h8000_0000, 32'h0000_0001));
    send_operands(make_op(32'h7FFF_FFFF, 32'h0000_0001));
    send_operands(make_op(32'h0000_7FFF, 32'h0000_0001));
    send_operands(make_op(32'h0000_8000, 32'h0000_0001));
    send_operands(make_op(32'hFFFF_8000, 32'h0000_0001));
    send_operands(make_op(32'h0000_8000, 32'hFFFF_FFFF));
    send_operands(make_op(32'h0000_0000, 32'h8000_0000));
    send_operands(make_op(32'h0001_0000, 32'h0000_0000));
    send_operands(make_op(32'h8000_0000, 32'h0000_0000));
    send_operands(make_op(32'h7FFF_FFFF, 32'h0000_0000));
    send_operands(make_op(32'h0000_0000, 32'h0000_0000));

    // Random part: bursts of transfers separated by random gaps. Some bursts are
    // long enough to run with no idling at all.
    burst_left = $urandom_range(1, 40);
    for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
      if (burst_left == 0) begin
        pause_input($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 40);
      end
      burst_left--;
      send_operands(random_operands());
    end
    in_valid <= 1'b0;

    // Drain everything still in flight, then watch for stray results.
    while (sb.pending_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/q16div_pkg.sv
hdl/q16div_stage.sv
hdl/signed_q16_fixed_point_divider_top.sv
hdl/q16div_checker.sv
tb/signed_q16_fixed_point_divider_top_tb.sv
